// ----- rtl/eiafc_pkg.sv -----
// Shared types, codes and a helper function of the Ethernet IPv4/ARP frame classifier.
`default_nettype none

package eiafc_pkg;

   localparam int FRAME_WORD_W = 16;
   localparam int MAC_W        = 48;
   localparam int IP_W         = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 48;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
   localparam logic [15:0] WORD_ONES      = 16'hffff;
   localparam logic [15:0] WORD_ZERO      = 16'h0000;
   localparam logic [15:0] IP_HEADER_LEN  = 16'd20;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'h08;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_STATION_MAC = 1'b0,
      REG_STATION_IP  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_MAC_REJECT   = 3'd0,
      VERDICT_HDR_SUM_BAD  = 3'd1,
      VERDICT_IP_MISMATCH  = 3'd2,
      VERDICT_ECHO_OK      = 3'd3,
      VERDICT_ECHO_SUM_BAD = 3'd4,
      VERDICT_IP_OTHER     = 3'd5,
      VERDICT_ARP_FOR_US   = 3'd6,
      VERDICT_OTHER        = 3'd7
   } verdict_type;

   // Everything the back end needs to judge one finished frame.
   typedef struct packed {
      logic        mac_hit;
      logic [15:0] ether_kind;
      logic [15:0] header_sum;
      logic [15:0] header_sum_rx;
      logic [1:0]  dest_ip_match;
      logic [7:0]  protocol;
      logic [7:0]  icmp_type;
      logic [15:0] icmp_sum;
      logic [15:0] icmp_sum_rx;
      logic [15:0] arp_opcode;
      logic [1:0]  arp_target_match;
   } frame_summary_type;

   // Ones-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, w};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/eiafc_if.sv -----
// Handshake channel interfaces: frame words in, verdicts out, register writes.
`default_nettype none

interface eiafc_word_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_word;
   logic        last_word;

   modport source (output valid, output frame_word, output last_word, input ready);
   modport sink   (input valid, input frame_word, input last_word, output ready);
endinterface

interface eiafc_verdict_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic [7:0] ip_protocol;

   modport source (output valid, output verdict, output ip_protocol, input ready);
   modport sink   (input valid, input verdict, input ip_protocol, output ready);
endinterface

interface eiafc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [47:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ethernet_ip_arp_frame_classifier.sv -----
// Top level of the Ethernet IPv4/ARP receive frame classifier.
//
// Frame words enter on req_chan at one word per clock while ready is high, and one
// verdict word leaves on rsp_chan per frame once its summary has passed the queue and
// the output register. The front end folds each word into the running checksums and
// field matches as it arrives, which sets the rate of one word per cycle; finished frame
// summaries pass through a two-entry queue to the back end, which forms the verdict in
// an output register. Input ready drops only while the queue holds two frames whose
// verdicts are still waiting behind a stalled output. Registers are written on csr_chan,
// which is always ready; words beyond MAX_FRAME_WORDS in one frame are ignored.
`default_nettype none

module ethernet_ip_arp_frame_classifier
   import eiafc_pkg::*;
#(
   parameter int MAX_FRAME_WORDS = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   eiafc_word_if.sink         req_chan,
   eiafc_verdict_if.source    rsp_chan,
   eiafc_csr_if.sink          csr_chan
);

   logic [MAC_W-1:0]  station_mac_ff;
   logic [IP_W-1:0]   station_ip_ff;
   logic              queue_full;
   logic              word_accept;
   logic              push_valid;
   frame_summary_type push_data;
   logic              pop_valid;
   frame_summary_type pop_data;
   logic              pop;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_full;
   assign word_accept    = req_chan.valid && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_mac_ff <= '0;
         station_ip_ff  <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            REG_STATION_MAC: station_mac_ff <= csr_chan.data[MAC_W-1:0];
            REG_STATION_IP:  station_ip_ff  <= csr_chan.data[IP_W-1:0];
            default: ;
         endcase
      end
   end

   eiafc_front #(
      .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (word_accept),
      .word_data   (req_chan.frame_word),
      .word_last   (req_chan.last_word),
      .station_mac (station_mac_ff),
      .station_ip  (station_ip_ff),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   eiafc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   eiafc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (pop_valid),
      .sum_data  (pop_data),
      .sum_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- rtl/eiafc_front.sv -----
// Front end: accumulates one frame word per cycle while input ready is high and builds the frame summary.
`default_nettype none

module eiafc_front
   import eiafc_pkg::*;
#(
   parameter int MAX_FRAME_WORDS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              word_valid,
   input  wire logic [15:0]       word_data,
   input  wire logic              word_last,
   input  wire logic [MAC_W-1:0]  station_mac,
   input  wire logic [IP_W-1:0]   station_ip,
   output logic                   push_valid,
   output frame_summary_type      push_data
);

   localparam int POS_W = $clog2(MAX_FRAME_WORDS + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_WORDS);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       mac_flags_ff, mac_flags_in;
   logic [15:0]      ether_kind_ff, ether_kind_in;
   logic [15:0]      hsum_ff, hsum_in;
   logic [15:0]      hsum_rx_ff, hsum_rx_in;
   logic [14:0]      icmp_words_ff, icmp_words_in;
   logic [7:0]       proto_ff, proto_in;
   logic [1:0]       dip_ff, dip_in;
   logic [7:0]       icmp_type_ff, icmp_type_in;
   logic [15:0]      isum_ff, isum_in;
   logic [15:0]      isum_rx_ff, isum_rx_in;
   logic [15:0]      opcode_ff, opcode_in;
   logic [1:0]       arp_ff, arp_in;

   logic        take;
   logic [15:0] ip_hi, ip_lo, mac_w, len_minus_hdr;
   logic [2:0]  flags_eff;

   assign ip_hi = station_ip[31:16];
   assign ip_lo = station_ip[15:0];
   assign take  = word_valid && (pos_ff < POS_MAX);
   assign len_minus_hdr = word_data - IP_HEADER_LEN;

   always_comb begin
      case (pos_ff)
         POS_W'(0): mac_w = station_mac[47:32];
         POS_W'(1): mac_w = station_mac[31:16];
         default:   mac_w = station_mac[15:0];
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      mac_flags_in  = mac_flags_ff;
      ether_kind_in = ether_kind_ff;
      hsum_in       = hsum_ff;
      hsum_rx_in    = hsum_rx_ff;
      icmp_words_in = icmp_words_ff;
      proto_in      = proto_ff;
      dip_in        = dip_ff;
      icmp_type_in  = icmp_type_ff;
      isum_in       = isum_ff;
      isum_rx_in    = isum_rx_ff;
      opcode_in     = opcode_ff;
      arp_in        = arp_ff;
      if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff < POS_W'(3)) begin
            if (word_data != WORD_ONES) mac_flags_in[0] = 1'b0;
            if (word_data != WORD_ZERO) mac_flags_in[1] = 1'b0;
            if (word_data != mac_w)     mac_flags_in[2] = 1'b0;
         end
         if (pos_ff == POS_W'(6))  ether_kind_in = word_data;
         if (pos_ff == POS_W'(8))  icmp_words_in = len_minus_hdr[15:1];
         if (pos_ff == POS_W'(10)) opcode_in = word_data;
         if (pos_ff == POS_W'(11)) proto_in = word_data[7:0];
         if (pos_ff >= POS_W'(7) && pos_ff <= POS_W'(16)) begin
            if (pos_ff == POS_W'(12)) hsum_rx_in = word_data;
            else hsum_in = ones_add(hsum_ff, word_data);
         end
         if (pos_ff == POS_W'(15) && word_data == ip_hi) dip_in[0] = 1'b1;
         if (pos_ff == POS_W'(16) && word_data == ip_lo) dip_in[1] = 1'b1;
         if (pos_ff == POS_W'(17)) icmp_type_in = word_data[15:8];
         if (pos_ff == POS_W'(18)) isum_rx_in = word_data;
         // The ICMP sum covers the payload words counted from word 17, minus the sum word.
         if (pos_ff >= POS_W'(17) && pos_ff != POS_W'(18) &&
             16'(pos_ff - POS_W'(17)) < {1'b0, icmp_words_ff}) begin
            isum_in = ones_add(isum_ff, word_data);
         end
         if (pos_ff == POS_W'(19) && word_data == ip_hi) arp_in[0] = 1'b1;
         if (pos_ff == POS_W'(20) && word_data == ip_lo) arp_in[1] = 1'b1;
      end
   end

   // Words missing from a short frame count as zero; only these flags can change then.
   always_comb begin
      flags_eff[0] = mac_flags_in[0] && (pos_in > POS_W'(2));
      flags_eff[1] = mac_flags_in[1];
      flags_eff[2] = mac_flags_in[2]
                     && !(pos_in <= POS_W'(1) && station_mac[31:16] != WORD_ZERO)
                     && !(pos_in <= POS_W'(2) && station_mac[15:0] != WORD_ZERO);

      push_data.mac_hit          = |flags_eff;
      push_data.ether_kind       = ether_kind_in;
      push_data.header_sum       = hsum_in;
      push_data.header_sum_rx    = hsum_rx_in;
      push_data.dest_ip_match[0] = dip_in[0] || (pos_in <= POS_W'(15) && ip_hi == WORD_ZERO);
      push_data.dest_ip_match[1] = dip_in[1] || (pos_in <= POS_W'(16) && ip_lo == WORD_ZERO);
      push_data.protocol         = proto_in;
      push_data.icmp_type        = icmp_type_in;
      push_data.icmp_sum         = isum_in;
      push_data.icmp_sum_rx      = isum_rx_in;
      push_data.arp_opcode       = opcode_in;
      push_data.arp_target_match[0] = arp_in[0] || (pos_in <= POS_W'(19) && ip_hi == WORD_ZERO);
      push_data.arp_target_match[1] = arp_in[1] || (pos_in <= POS_W'(20) && ip_lo == WORD_ZERO);
   end

   assign push_valid = word_valid && word_last;

   always_ff @(posedge clock) begin
      if (reset || push_valid) begin
         pos_ff        <= '0;
         mac_flags_ff  <= 3'b111;
         ether_kind_ff <= '0;
         hsum_ff       <= '0;
         hsum_rx_ff    <= '0;
         icmp_words_ff <= '0;
         proto_ff      <= '0;
         dip_ff        <= '0;
         icmp_type_ff  <= '0;
         isum_ff       <= '0;
         isum_rx_ff    <= '0;
         opcode_ff     <= '0;
         arp_ff        <= '0;
      end else begin
         pos_ff        <= pos_in;
         mac_flags_ff  <= mac_flags_in;
         ether_kind_ff <= ether_kind_in;
         hsum_ff       <= hsum_in;
         hsum_rx_ff    <= hsum_rx_in;
         icmp_words_ff <= icmp_words_in;
         proto_ff      <= proto_in;
         dip_ff        <= dip_in;
         icmp_type_ff  <= icmp_type_in;
         isum_ff       <= isum_in;
         isum_rx_ff    <= isum_rx_in;
         opcode_ff     <= opcode_in;
         arp_ff        <= arp_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/eiafc_queue.sv -----
// Short queue of frame summaries between the front and back ends.
`default_nettype none

module eiafc_queue
   import eiafc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire frame_summary_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output frame_summary_type      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_summary_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/eiafc_back.sv -----
// Back end: turns a frame summary into a verdict and holds it in the output register.
`default_nettype none

module eiafc_back
   import eiafc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              sum_valid,
   input  wire frame_summary_type sum_data,
   output logic                   sum_pop,
   eiafc_verdict_if.source        rsp_chan
);

   logic        valid_ff;
   verdict_type verdict_ff, verdict_in;
   logic [7:0]  proto_ff, proto_in;
   logic        load;
   logic        is_ipv4;

   assign load    = sum_valid && (!valid_ff || rsp_chan.ready);
   assign sum_pop = load;
   assign is_ipv4 = (sum_data.ether_kind == ETHERTYPE_IPV4);

   always_comb begin
      proto_in = is_ipv4 ? sum_data.protocol : 8'd0;
      if (!sum_data.mac_hit) begin
         verdict_in = VERDICT_MAC_REJECT;
      end else if (is_ipv4) begin
         if (sum_data.header_sum_rx != ~sum_data.header_sum) begin
            verdict_in = VERDICT_HDR_SUM_BAD;
         end else if (sum_data.dest_ip_match != 2'b11) begin
            verdict_in = VERDICT_IP_MISMATCH;
         end else if (sum_data.icmp_type == ICMP_ECHO_REQ &&
                      sum_data.protocol == IP_PROTO_ICMP) begin
            verdict_in = (sum_data.icmp_sum_rx == ~sum_data.icmp_sum) ?
                         VERDICT_ECHO_OK : VERDICT_ECHO_SUM_BAD;
         end else begin
            verdict_in = VERDICT_IP_OTHER;
         end
      end else if (sum_data.ether_kind == ETHERTYPE_ARP &&
                   sum_data.arp_opcode == ARP_OP_REQUEST &&
                   sum_data.arp_target_match == 2'b11) begin
         verdict_in = VERDICT_ARP_FOR_US;
      end else begin
         verdict_in = VERDICT_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict_in;
         proto_ff   <= proto_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.verdict     = verdict_ff;
   assign rsp_chan.ip_protocol = proto_ff;

endmodule

`default_nettype wire
